FILE: hdl/rbs_pkg.sv
// Shared package for the ray / box slab intersection block.
// Holds the default number format and the per-slab flag type.
// No dependencies.
package rbs_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int NUM_AXES       = 3;

    typedef struct packed {
        logic dzero;
        logic in_slab;
    } slab_flags_t;

endpackage

FILE: hdl/rbs_div.sv
// Pipelined restoring divider, one quotient bit per stage, for slab distances.
// Keeps the low COORD_BITS quotient bits and a sticky overflow flag.
// Depends on nothing beyond its parameters.
module rbs_div #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic [COORD_BITS+FRAC_BITS:0]       num,
    input  logic [COORD_BITS-1:0]               den,
    output logic [COORD_BITS-1:0]               quo,
    output logic                                ovf
);

    localparam int NW = COORD_BITS + FRAC_BITS + 1;

    logic [COORD_BITS-1:0] rem_reg [NW];
    logic [NW-1:0]         num_reg [NW];
    logic [COORD_BITS-1:0] den_reg [NW];
    logic [COORD_BITS-1:0] quo_reg [NW];
    logic                  ovf_reg [NW];

    genvar i;
    generate
        for (i = 0; i < NW; i++) begin : g_stage
            localparam int B = NW - 1 - i;
            logic [COORD_BITS-1:0] rem_in;
            logic [NW-1:0]         num_in;
            logic [COORD_BITS-1:0] den_in;
            logic [COORD_BITS-1:0] quo_in;
            logic                  ovf_in;
            logic [COORD_BITS:0]   trial;
            logic [COORD_BITS:0]   diff;
            logic                  ge;

            if (i == 0) begin : g_first
                assign rem_in = '0;
                assign num_in = num;
                assign den_in = den;
                assign quo_in = '0;
                assign ovf_in = 1'b0;
            end else begin : g_next
                assign rem_in = rem_reg[i-1];
                assign num_in = num_reg[i-1];
                assign den_in = den_reg[i-1];
                assign quo_in = quo_reg[i-1];
                assign ovf_in = ovf_reg[i-1];
            end

            assign trial = {rem_in, num_in[NW-1]};
            assign ge    = (trial >= {1'b0, den_in});
            assign diff  = trial - {1'b0, den_in};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
                    num_reg[i] <= {num_in[NW-2:0], 1'b0};
                    den_reg[i] <= den_in;
                    if (B >= COORD_BITS)
                    begin
                        quo_reg[i] <= quo_in;
                        ovf_reg[i] <= ovf_in | ge;
                    end
                    else
                    begin
                        quo_reg[i] <= quo_in | (ge ? (COORD_BITS'(1) << B) : '0);
                        ovf_reg[i] <= ovf_in;
                    end
                end
            end
        end
    endgenerate

    assign quo = quo_reg[NW-1];
    assign ovf = ovf_reg[NW-1];

endmodule

FILE: hdl/rbs_slab_lane.sv
// One axis lane: slab distances for the min and max planes, saturated and ordered.
// Depends on rbs_pkg and rbs_div.
module rbs_slab_lane #(
    parameter int COORD_BITS = rbs_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = rbs_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [COORD_BITS-1:0]  org,
    input  logic signed [COORD_BITS-1:0]  dir,
    input  logic signed [COORD_BITS-1:0]  bmin,
    input  logic signed [COORD_BITS-1:0]  bmax,
    output logic signed [COORD_BITS-1:0]  t_lo,
    output logic signed [COORD_BITS-1:0]  t_hi,
    output rbs_pkg::slab_flags_t          flags,
    output logic signed [COORD_BITS-1:0]  org_out,
    output logic signed [COORD_BITS-1:0]  dir_out
);

    localparam int NW = COORD_BITS + FRAC_BITS + 1;
    localparam logic [COORD_BITS-1:0] POS_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] NEG_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic signed [COORD_BITS:0] diff0, diff1;
    logic                       ng0, ng1;

    logic [COORD_BITS:0]        mag0_reg, mag1_reg;
    logic [COORD_BITS-1:0]      dm_reg;
    logic                       neg0_reg, neg1_reg;
    rbs_pkg::slab_flags_t       flg_reg;
    logic [COORD_BITS-1:0]      org_reg, dir_reg;

    logic                       sneg0 [NW];
    logic                       sneg1 [NW];
    rbs_pkg::slab_flags_t       sflg [NW];
    logic [COORD_BITS-1:0]      sorg [NW];
    logic [COORD_BITS-1:0]      sdir [NW];

    logic [COORD_BITS-1:0]      q0, q1;
    logic                       ovf0, ovf1;
    logic [COORD_BITS-1:0]      t0_next, t1_next;
    logic [COORD_BITS-1:0]      t0_reg, t1_reg;
    rbs_pkg::slab_flags_t       flg2_reg;
    logic [COORD_BITS-1:0]      org2_reg, dir2_reg;

    logic [COORD_BITS-1:0]      tlo_reg, thi_reg;
    rbs_pkg::slab_flags_t       flg3_reg;
    logic [COORD_BITS-1:0]      org3_reg, dir3_reg;

    assign diff0 = {bmin[COORD_BITS-1], bmin} - {org[COORD_BITS-1], org};
    assign diff1 = {bmax[COORD_BITS-1], bmax} - {org[COORD_BITS-1], org};
    assign ng0   = (bmin < org);
    assign ng1   = (bmax < org);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag0_reg        <= ng0 ? (-diff0) : diff0;
            mag1_reg        <= ng1 ? (-diff1) : diff1;
            dm_reg          <= dir[COORD_BITS-1] ? (-dir) : dir;
            neg0_reg        <= ng0 ^ dir[COORD_BITS-1];
            neg1_reg        <= ng1 ^ dir[COORD_BITS-1];
            flg_reg.dzero   <= (dir == '0);
            flg_reg.in_slab <= !((org < bmin) || (bmax < org));
            org_reg         <= org;
            dir_reg         <= dir;
        end
    end

    rbs_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div0 (
        .clk (clk),
        .en  (en),
        .num ({mag0_reg, {FRAC_BITS{1'b0}}}),
        .den (dm_reg),
        .quo (q0),
        .ovf (ovf0)
    );

    rbs_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div1 (
        .clk (clk),
        .en  (en),
        .num ({mag1_reg, {FRAC_BITS{1'b0}}}),
        .den (dm_reg),
        .quo (q1),
        .ovf (ovf1)
    );

    genvar k;
    generate
        for (k = 0; k < NW; k++) begin : g_side
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (k == 0)
                    begin
                        sneg0[k] <= neg0_reg;
                        sneg1[k] <= neg1_reg;
                        sflg[k]  <= flg_reg;
                        sorg[k]  <= org_reg;
                        sdir[k]  <= dir_reg;
                    end
                    else
                    begin
                        sneg0[k] <= sneg0[k-1];
                        sneg1[k] <= sneg1[k-1];
                        sflg[k]  <= sflg[k-1];
                        sorg[k]  <= sorg[k-1];
                        sdir[k]  <= sdir[k-1];
                    end
                end
            end
        end
    endgenerate

    always_comb
    begin
        if (sneg0[NW-1])
            t0_next = (ovf0 || (q0 > NEG_MIN)) ? NEG_MIN : (-q0);
        else
            t0_next = (ovf0 || (q0 > POS_MAX)) ? POS_MAX : q0;
        if (sneg1[NW-1])
            t1_next = (ovf1 || (q1 > NEG_MIN)) ? NEG_MIN : (-q1);
        else
            t1_next = (ovf1 || (q1 > POS_MAX)) ? POS_MAX : q1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t0_reg   <= t0_next;
            t1_reg   <= t1_next;
            flg2_reg <= sflg[NW-1];
            org2_reg <= sorg[NW-1];
            dir2_reg <= sdir[NW-1];
            if ($signed(t1_reg) < $signed(t0_reg))
            begin
                tlo_reg <= t1_reg;
                thi_reg <= t0_reg;
            end
            else
            begin
                tlo_reg <= t0_reg;
                thi_reg <= t1_reg;
            end
            flg3_reg <= flg2_reg;
            org3_reg <= org2_reg;
            dir3_reg <= dir2_reg;
        end
    end

    assign t_lo    = tlo_reg;
    assign t_hi    = thi_reg;
    assign flags   = flg3_reg;
    assign org_out = org3_reg;
    assign dir_out = dir3_reg;

endmodule

FILE: hdl/rbs_merge.sv
// Combines the three lanes' slabs into one interval and picks the hit distance.
// Depends on rbs_pkg.
module rbs_merge #(
    parameter int COORD_BITS = rbs_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [COORD_BITS-1:0]  t_lo [rbs_pkg::NUM_AXES],
    input  logic signed [COORD_BITS-1:0]  t_hi [rbs_pkg::NUM_AXES],
    input  rbs_pkg::slab_flags_t          flags [rbs_pkg::NUM_AXES],
    input  logic signed [COORD_BITS-1:0]  org [rbs_pkg::NUM_AXES],
    input  logic signed [COORD_BITS-1:0]  dir [rbs_pkg::NUM_AXES],
    output logic                          hit,
    output logic signed [COORD_BITS-1:0]  t_sel,
    output logic signed [COORD_BITS-1:0]  org_out [rbs_pkg::NUM_AXES],
    output logic signed [COORD_BITS-1:0]  dir_out [rbs_pkg::NUM_AXES]
);

    localparam logic signed [COORD_BITS-1:0] POS_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] NEG_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic signed [COORD_BITS-1:0] near_next, far_next;
    logic                         zmiss_next;
    logic signed [COORD_BITS-1:0] near_reg, far_reg;
    logic                         zmiss_reg;
    logic signed [COORD_BITS-1:0] org1_reg [rbs_pkg::NUM_AXES];
    logic signed [COORD_BITS-1:0] dir1_reg [rbs_pkg::NUM_AXES];
    logic                         hit_reg;
    logic signed [COORD_BITS-1:0] t_reg;
    logic signed [COORD_BITS-1:0] org2_reg [rbs_pkg::NUM_AXES];
    logic signed [COORD_BITS-1:0] dir2_reg [rbs_pkg::NUM_AXES];

    always_comb
    begin
        near_next  = NEG_MIN;
        far_next   = POS_MAX;
        zmiss_next = 1'b0;
        for (int a = 0; a < rbs_pkg::NUM_AXES; a++)
        begin
            if (flags[a].dzero)
            begin
                zmiss_next = zmiss_next | !flags[a].in_slab;
            end
            else
            begin
                if (near_next < t_lo[a])
                    near_next = t_lo[a];
                if (t_hi[a] < far_next)
                    far_next = t_hi[a];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            near_reg  <= near_next;
            far_reg   <= far_next;
            zmiss_reg <= zmiss_next;
            hit_reg   <= !(zmiss_reg || (far_reg < near_reg));
            t_reg     <= near_reg[COORD_BITS-1] ? far_reg : near_reg;
            for (int a = 0; a < rbs_pkg::NUM_AXES; a++)
            begin
                org1_reg[a] <= org[a];
                dir1_reg[a] <= dir[a];
                org2_reg[a] <= org1_reg[a];
                dir2_reg[a] <= dir1_reg[a];
            end
        end
    end

    assign hit     = hit_reg;
    assign t_sel   = t_reg;
    assign org_out = org2_reg;
    assign dir_out = dir2_reg;

endmodule

FILE: hdl/rbs_point.sv
// Computes one point coordinate, origin plus direction times distance, saturated.
// Two stages: magnitude product, then add, floor shift and clamp. Depends on rbs_pkg.
module rbs_point #(
    parameter int COORD_BITS = rbs_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = rbs_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic                          hit,
    input  logic signed [COORD_BITS-1:0]  org,
    input  logic signed [COORD_BITS-1:0]  dir,
    input  logic signed [COORD_BITS-1:0]  t_sel,
    output logic                          hit_out,
    output logic signed [COORD_BITS-1:0]  coord
);

    localparam int W = 2 * COORD_BITS + 2;
    localparam logic signed [COORD_BITS-1:0] POS_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] NEG_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic [COORD_BITS-1:0]       dm, tm;
    logic [2*COORD_BITS-1:0]     prod_reg;
    logic                        neg_reg;
    logic                        hit1_reg;
    logic signed [COORD_BITS-1:0] org1_reg;
    logic signed [W-1:0]         sp, os, sum, sh;
    logic signed [COORD_BITS-1:0] coord_next;
    logic signed [COORD_BITS-1:0] coord_reg;
    logic                        hit2_reg;

    assign dm = dir[COORD_BITS-1] ? (-dir) : dir;
    assign tm = t_sel[COORD_BITS-1] ? (-t_sel) : t_sel;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= dm * tm;
            neg_reg  <= dir[COORD_BITS-1] ^ t_sel[COORD_BITS-1];
            hit1_reg <= hit;
            org1_reg <= org;
        end
    end

    always_comb
    begin
        sp  = neg_reg ? -$signed({2'b00, prod_reg}) : $signed({2'b00, prod_reg});
        os  = W'(org1_reg) <<< FRAC_BITS;
        sum = os + sp;
        sh  = sum >>> FRAC_BITS;
        if (!hit1_reg)
            coord_next = '0;
        else if (sh > W'(POS_MAX))
            coord_next = POS_MAX;
        else if (sh < W'(NEG_MIN))
            coord_next = NEG_MIN;
        else
            coord_next = sh[COORD_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coord_reg <= coord_next;
            hit2_reg  <= hit1_reg;
        end
    end

    assign coord   = coord_reg;
    assign hit_out = hit2_reg;

endmodule

FILE: hdl/ray_box_slab_intersect_top.sv
// Ray / axis-aligned box slab intersection, one request accepted per clock unless
// stalled: s_tready drops only while the skid stage holds a result. The slab dividers
// resolve one quotient bit per stage; the default format is Q16.16.
// An output register with a skid stage decouples the two sides.
// Reset (rst_n, asynchronous, active low) clears all valid flags; data is not reset.
module ray_box_slab_intersect_top #(
    parameter int COORD_BITS = rbs_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = rbs_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, box_min_x, box_min_y,
    // box_min_z, box_max_x, box_max_y, box_max_z, then zero padding.
    input  logic [((12*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // point_x, point_y, point_z, then zero padding.
    output logic [((3*COORD_BITS+7)/8)*8-1:0]  m_tdata,
    // hit.
    output logic                 m_tuser
);

    localparam int NA    = rbs_pkg::NUM_AXES;
    localparam int OUT_W = ((3*COORD_BITS+7)/8)*8;
    localparam int LAT   = COORD_BITS + FRAC_BITS + 8;

    logic                         en;
    logic [LAT-1:0]               vld_reg;

    logic signed [COORD_BITS-1:0] t_lo [NA];
    logic signed [COORD_BITS-1:0] t_hi [NA];
    rbs_pkg::slab_flags_t         flags [NA];
    logic signed [COORD_BITS-1:0] org_l [NA];
    logic signed [COORD_BITS-1:0] dir_l [NA];
    logic                         hit_m;
    logic signed [COORD_BITS-1:0] t_sel;
    logic signed [COORD_BITS-1:0] org_m [NA];
    logic signed [COORD_BITS-1:0] dir_m [NA];
    logic                         hit_p [NA];
    logic signed [COORD_BITS-1:0] coord [NA];

    logic                         out_vld_reg, skid_vld_reg;
    logic [3*COORD_BITS:0]        out_dat_reg, skid_dat_reg;
    logic [3*COORD_BITS:0]        new_dat;
    logic                         incoming, take;

    assign en       = !skid_vld_reg;
    assign s_tready = en;

    genvar a;
    generate
        for (a = 0; a < NA; a++) begin : g_lane
            rbs_slab_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane (
                .clk     (clk),
                .en      (en),
                .org     (s_tdata[a*COORD_BITS +: COORD_BITS]),
                .dir     (s_tdata[(3+a)*COORD_BITS +: COORD_BITS]),
                .bmin    (s_tdata[(6+a)*COORD_BITS +: COORD_BITS]),
                .bmax    (s_tdata[(9+a)*COORD_BITS +: COORD_BITS]),
                .t_lo    (t_lo[a]),
                .t_hi    (t_hi[a]),
                .flags   (flags[a]),
                .org_out (org_l[a]),
                .dir_out (dir_l[a])
            );

            rbs_point #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_point (
                .clk     (clk),
                .en      (en),
                .hit     (hit_m),
                .org     (org_m[a]),
                .dir     (dir_m[a]),
                .t_sel   (t_sel),
                .hit_out (hit_p[a]),
                .coord   (coord[a])
            );
        end
    endgenerate

    rbs_merge #(.COORD_BITS(COORD_BITS)) u_merge (
        .clk     (clk),
        .en      (en),
        .t_lo    (t_lo),
        .t_hi    (t_hi),
        .flags   (flags),
        .org     (org_l),
        .dir     (dir_l),
        .hit     (hit_m),
        .t_sel   (t_sel),
        .org_out (org_m),
        .dir_out (dir_m)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
    end

    assign new_dat  = {coord[2], coord[1], coord[0], hit_p[0]};
    assign incoming = en && vld_reg[LAT-1];
    assign take     = out_vld_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (take)
                skid_vld_reg <= 1'b0;
        end
        else if (incoming)
        begin
            if (out_vld_reg && !take)
                skid_vld_reg <= 1'b1;
            else
                out_vld_reg <= 1'b1;
        end
        else if (take)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (take)
                out_dat_reg <= skid_dat_reg;
        end
        else if (incoming)
        begin
            if (out_vld_reg && !take)
                skid_dat_reg <= new_dat;
            else
                out_dat_reg <= new_dat;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_dat_reg[0];
    assign m_tdata  = OUT_W'(out_dat_reg[3*COORD_BITS:1]);

endmodule
